@@ hw/rtl/smma_pkg.sv @@
// Shared types, codes and helpers for the scaled matrix multiply-accumulate block.
// No dependencies; imported by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package smma_pkg;

    localparam int DEF_MAX_DIM     = 8;
    localparam int DEF_VALUE_WIDTH = 32;
    localparam int FRAC_BITS       = 16;
    localparam int INDEX_W         = 6;
    localparam int CFG_INDEX_W     = 3;

    localparam logic [1:0] ACT_WRITE_A = 2'd0;
    localparam logic [1:0] ACT_WRITE_B = 2'd1;
    localparam logic [1:0] ACT_WRITE_C = 2'd2;
    localparam logic [1:0] ACT_COMPUTE = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_ALPHA  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BETA   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ROWS   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_INNER  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COLS   = 3'd4;

    localparam logic [1:0] MUL_AB  = 2'd0;
    localparam logic [1:0] MUL_ALO = 2'd1;
    localparam logic [1:0] MUL_AHI = 2'd2;
    localparam logic [1:0] MUL_BC  = 2'd3;

    typedef struct packed {
        logic [1:0]          action;
        logic [INDEX_W-1:0]  element_index;
        logic signed [31:0]  element_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0]  result_value;
        logic [INDEX_W-1:0]  result_index;
        logic                last_flag;
    } out_item_t;

    typedef struct packed {
        logic                wr_a;
        logic                wr_b;
        logic                wr_c;
        logic                rd;
        logic                rd_c;
        logic                acc_clr;
        logic [1:0]          mul_sel;
        logic                t_load;
        logic                t_add_hi;
        logic                t_add_c;
        logic                emit;
        logic                last;
        logic [INDEX_W-1:0]  a_addr;
        logic [INDEX_W-1:0]  b_addr;
        logic [INDEX_W-1:0]  c_addr;
    } dp_cmd_t;

    typedef struct packed {
        logic out_busy;
    } dp_status_t;

    function automatic logic [3:0] dim_clamp(input logic [3:0] v, input logic [3:0] max_dim);
        logic [3:0] r;
        if (v == 4'd0)
            r = 4'd1;
        else if (v > max_dim)
            r = max_dim;
        else
            r = v;
        return r;
    endfunction

endpackage

@@ hw/rtl/smma_ctrl.sv @@
// Sequencing state machine: load address checks, element/inner loop counters, datapath commands.
// Depends on smma_pkg.
`timescale 1ns / 1ps

module smma_ctrl
    import smma_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    input  logic [3:0]  row_count,
    input  logic [3:0]  inner_count,
    input  logic [3:0]  column_count,
    input  dp_status_t  status,
    output dp_cmd_t     cmd
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    localparam logic [3:0] ST_IDLE     = 4'd0;
    localparam logic [3:0] ST_MAC      = 4'd1;
    localparam logic [3:0] ST_DRAIN0   = 4'd2;
    localparam logic [3:0] ST_DRAIN1   = 4'd3;
    localparam logic [3:0] ST_SCALE_LO = 4'd4;
    localparam logic [3:0] ST_SCALE_HI = 4'd5;
    localparam logic [3:0] ST_SCALE_C  = 4'd6;
    localparam logic [3:0] ST_SUM_C    = 4'd7;
    localparam logic [3:0] ST_EMIT     = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [CNT_W-1:0]  k_reg, k_next;
    logic [ADDR_W-1:0] ij_reg, ij_next;
    logic [ADDR_W-1:0] a_addr_reg, a_addr_next;
    logic [ADDR_W-1:0] b_addr_reg, b_addr_next;
    logic [ADDR_W-1:0] b_base_reg, b_base_next;

    logic [3:0] n_dim, m_dim, p_dim;
    logic       accept;
    logic [6:0] idx_ext;
    logic       idx_in_depth;
    logic       i_last, j_last, k_last;

    assign n_dim = dim_clamp(row_count, 4'(MAX_DIM));
    assign m_dim = dim_clamp(inner_count, 4'(MAX_DIM));
    assign p_dim = dim_clamp(column_count, 4'(MAX_DIM));

    assign in_stall     = (state_reg != ST_IDLE);
    assign accept       = in_valid && !in_stall;
    assign idx_ext      = 7'(in_data.element_index);
    assign idx_in_depth = idx_ext < 7'(DEPTH);

    assign i_last = (4'(i_reg) == n_dim - 4'd1);
    assign j_last = (4'(j_reg) == p_dim - 4'd1);
    assign k_last = (4'(k_reg) == m_dim - 4'd1);

    always_comb
    begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        k_next      = k_reg;
        ij_next     = ij_reg;
        a_addr_next = a_addr_reg;
        b_addr_next = b_addr_reg;
        b_base_next = b_base_reg;

        cmd          = '0;
        cmd.mul_sel  = MUL_AB;
        cmd.a_addr   = INDEX_W'(a_addr_reg);
        cmd.b_addr   = INDEX_W'(b_addr_reg);
        cmd.c_addr   = INDEX_W'(ij_reg);
        cmd.last     = i_last && j_last;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (in_data.action)
                        ACT_WRITE_A:
                            cmd.wr_a = idx_in_depth && (idx_ext < 7'(n_dim) * 7'(m_dim));
                        ACT_WRITE_B:
                            cmd.wr_b = idx_in_depth && (idx_ext < 7'(m_dim) * 7'(p_dim));
                        ACT_WRITE_C:
                            cmd.wr_c = idx_in_depth && (idx_ext < 7'(n_dim) * 7'(p_dim));
                        default:
                        begin
                            state_next  = ST_MAC;
                            i_next      = '0;
                            j_next      = '0;
                            k_next      = '0;
                            ij_next     = '0;
                            a_addr_next = '0;
                            b_addr_next = '0;
                            b_base_next = '0;
                        end
                    endcase
                end
            end
            ST_MAC:
            begin
                cmd.rd      = 1'b1;
                cmd.rd_c    = (k_reg == '0);
                cmd.acc_clr = (k_reg == '0);
                a_addr_next = ADDR_W'(a_addr_reg + n_dim);
                b_addr_next = ADDR_W'(b_addr_reg + 1'b1);
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN0;
                end
                else
                begin
                    k_next = CNT_W'(k_reg + 1'b1);
                end
            end
            ST_DRAIN0:
                state_next = ST_DRAIN1;
            ST_DRAIN1:
                state_next = ST_SCALE_LO;
            ST_SCALE_LO:
            begin
                cmd.mul_sel = MUL_ALO;
                state_next  = ST_SCALE_HI;
            end
            ST_SCALE_HI:
            begin
                cmd.mul_sel = MUL_AHI;
                cmd.t_load  = 1'b1;
                state_next  = ST_SCALE_C;
            end
            ST_SCALE_C:
            begin
                cmd.mul_sel  = MUL_BC;
                cmd.t_add_hi = 1'b1;
                state_next   = ST_SUM_C;
            end
            ST_SUM_C:
            begin
                cmd.t_add_c = 1'b1;
                state_next  = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit = 1'b1;
                    ij_next  = ADDR_W'(ij_reg + 1'b1);
                    if (i_last && j_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (i_last)
                    begin
                        state_next  = ST_MAC;
                        i_next      = '0;
                        j_next      = CNT_W'(j_reg + 1'b1);
                        b_base_next = ADDR_W'(b_base_reg + m_dim);
                        a_addr_next = '0;
                        b_addr_next = ADDR_W'(b_base_reg + m_dim);
                    end
                    else
                    begin
                        state_next  = ST_MAC;
                        i_next      = CNT_W'(i_reg + 1'b1);
                        a_addr_next = ADDR_W'(i_reg + 1'b1);
                        b_addr_next = b_base_reg;
                    end
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            i_reg      <= '0;
            j_reg      <= '0;
            k_reg      <= '0;
            ij_reg     <= '0;
            a_addr_reg <= '0;
            b_addr_reg <= '0;
            b_base_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            i_reg      <= i_next;
            j_reg      <= j_next;
            k_reg      <= k_next;
            ij_reg     <= ij_next;
            a_addr_reg <= a_addr_next;
            b_addr_reg <= b_addr_next;
            b_base_reg <= b_base_next;
        end
    end

endmodule

@@ hw/rtl/smma_datapath.sv @@
// Matrix stores, shared multiplier, product accumulator, scaling sum, rounding and output register.
// Depends on smma_pkg; driven by commands from smma_ctrl.
`timescale 1ns / 1ps

module smma_datapath
    import smma_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_status_t         status,
    input  in_item_t           in_data,
    input  logic signed [31:0] alpha_gain,
    input  logic signed [31:0] beta_gain,
    output logic               out_valid,
    input  logic               out_stall,
    output out_item_t          out_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ACC_W  = 2 * VALUE_WIDTH + 3;
    localparam int HI_W   = ACC_W - 32;
    localparam int MUL_W  = (HI_W > 33) ? HI_W : 33;
    localparam int PROD_W = 2 * MUL_W;
    localparam int T_W    = ACC_W + 33;
    localparam int SH_W   = T_W - 3 * FRAC_BITS;
    localparam logic signed [T_W-1:0] ROUND_BIAS = T_W'(1) <<< (3 * FRAC_BITS - 1);

    logic signed [VALUE_WIDTH-1:0] a_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] b_mem [DEPTH];
    logic signed [VALUE_WIDTH-1:0] c_mem [DEPTH];

    logic signed [VALUE_WIDTH-1:0] a_rd_reg, b_rd_reg, c_rd_reg;
    logic                          rd_valid_reg, mac_valid_reg;
    logic signed [PROD_W-1:0]      prod_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [T_W-1:0]         t_reg;
    logic                          out_valid_reg;
    out_item_t                     out_data_reg;

    logic signed [MUL_W-1:0]       mul_a, mul_b;
    logic [ADDR_W-1:0]             wr_addr;
    logic signed [VALUE_WIDTH-1:0] wr_value;
    logic                          c_we;
    logic [ADDR_W-1:0]             c_waddr;
    logic signed [VALUE_WIDTH-1:0] c_wdata;
    logic [SH_W-1:0]               sh;
    logic [SH_W-VALUE_WIDTH:0]     upper;
    logic signed [VALUE_WIDTH-1:0] sat_value;

    assign wr_addr  = in_data.element_index[ADDR_W-1:0];
    assign wr_value = in_data.element_value[VALUE_WIDTH-1:0];

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_AB:
            begin
                mul_a = MUL_W'(a_rd_reg);
                mul_b = MUL_W'(b_rd_reg);
            end
            MUL_ALO:
            begin
                mul_a = MUL_W'(alpha_gain);
                mul_b = MUL_W'($signed({1'b0, acc_reg[31:0]}));
            end
            MUL_AHI:
            begin
                mul_a = MUL_W'(alpha_gain);
                mul_b = MUL_W'($signed(acc_reg[ACC_W-1:32]));
            end
            MUL_BC:
            begin
                mul_a = MUL_W'(beta_gain);
                mul_b = MUL_W'(c_rd_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign sh        = t_reg[T_W-1:3*FRAC_BITS];
    assign upper     = sh[SH_W-1:VALUE_WIDTH-1];
    assign sat_value = ((&upper) || !(|upper)) ? $signed(sh[VALUE_WIDTH-1:0])
                     : (sh[SH_W-1] ? $signed({1'b1, {(VALUE_WIDTH-1){1'b0}}})
                                   : $signed({1'b0, {(VALUE_WIDTH-1){1'b1}}}));

    assign c_we    = cmd.emit || cmd.wr_c;
    assign c_waddr = cmd.emit ? cmd.c_addr[ADDR_W-1:0] : wr_addr;
    assign c_wdata = cmd.emit ? sat_value : wr_value;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_a)
            a_mem[wr_addr] <= wr_value;
        if (cmd.wr_b)
            b_mem[wr_addr] <= wr_value;
        if (c_we)
            c_mem[c_waddr] <= c_wdata;
        if (cmd.rd)
        begin
            a_rd_reg <= a_mem[cmd.a_addr[ADDR_W-1:0]];
            b_rd_reg <= b_mem[cmd.b_addr[ADDR_W-1:0]];
        end
        if (cmd.rd_c)
            c_rd_reg <= c_mem[cmd.c_addr[ADDR_W-1:0]];
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (cmd.acc_clr)
            acc_reg <= '0;
        else if (mac_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        if (cmd.t_load)
            t_reg <= T_W'(prod_reg) + ROUND_BIAS;
        else if (cmd.t_add_hi)
            t_reg <= t_reg + (T_W'(prod_reg) <<< 32);
        else if (cmd.t_add_c)
            t_reg <= t_reg + (T_W'(prod_reg) <<< FRAC_BITS);
        if (cmd.emit)
        begin
            out_data_reg.result_value <= 32'(sat_value);
            out_data_reg.result_index <= cmd.c_addr;
            out_data_reg.last_flag    <= cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg  <= 1'b0;
            mac_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg  <= cmd.rd;
            mac_valid_reg <= rd_valid_reg;
            if (cmd.emit)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    assign status.out_busy = out_valid_reg && out_stall;
    assign out_valid       = out_valid_reg;
    assign out_data        = out_data_reg;

endmodule

@@ hw/rtl/scaled_matrix_multiply_accumulate.sv @@
// Top level: configuration registers and the controller/datapath pair.
// Depends on smma_pkg, smma_ctrl and smma_datapath.
//
//   Channel   Handshake               Payload
//   -------   ---------------------   ------------------------------------------
//   input     in_valid / in_stall     in_data  (action, element_index, element_value)
//   output    out_valid / out_stall   out_data (result_value, result_index, last_flag)
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A compute transaction runs through the accept step, then for each element inner reads
// through the one A/B read port and the shared multiplier, then the drain, scaling,
// rounding and emit steps. Output stalls hold the controller at the emit step; in_stall
// stays high until the last result is in the output register. The A, B and C stores have
// no reset or clearing pass.
`timescale 1ns / 1ps

module scaled_matrix_multiply_accumulate
    import smma_pkg::*;
#(
    parameter int MAX_DIM     = DEF_MAX_DIM,
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [31:0]            cfg_data
);

    logic signed [31:0] alpha_reg;
    logic signed [31:0] beta_reg;
    logic [3:0]         rows_reg;
    logic [3:0]         inner_reg;
    logic [3:0]         cols_reg;

    dp_cmd_t    cmd;
    dp_status_t status;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alpha_reg <= 32'sd65536;
            beta_reg  <= 32'sd0;
            rows_reg  <= 4'd8;
            inner_reg <= 4'd8;
            cols_reg  <= 4'd8;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ALPHA: alpha_reg <= cfg_data;
                REG_BETA:  beta_reg  <= cfg_data;
                REG_ROWS:  rows_reg  <= cfg_data[3:0];
                REG_INNER: inner_reg <= cfg_data[3:0];
                REG_COLS:  cols_reg  <= cfg_data[3:0];
                default:   ;
            endcase
        end
    end

    smma_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .row_count    (rows_reg),
        .inner_count  (inner_reg),
        .column_count (cols_reg),
        .status       (status),
        .cmd          (cmd)
    );

    smma_datapath #(
        .MAX_DIM     (MAX_DIM),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .in_data    (in_data),
        .alpha_gain (alpha_reg),
        .beta_gain  (beta_reg),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
